// File: rtl/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// Shared constants and types of the guarded run-length encoder.
// ----------------------------------------------------------------------------
package rle_pkg;

	localparam int SYMBOL_BITS_DEF = 64;   // default symbol storage width
	localparam int QUEUE_DEPTH_DEF = 4;    // default command queue depth
	localparam int VALUE_BITS      = 64;   // width of a result word
	localparam int GUARD_BITS      = 32;   // width of the guard register
	localparam logic [GUARD_BITS-1:0] GUARD_RESET = 32'd1;

	// Control part of one queued command. A command expands into up to
	// four result words: an optional guard word, an optional pair A
	// (raw, length) and an optional pair B (raw, length zero).
	typedef struct packed {
		logic                  g_en;    // emit a guard-valued length word
		logic                  a_en;    // emit pair A
		logic                  b_en;    // emit pair B
		logic                  last;    // final word carries block_done
		logic [GUARD_BITS-1:0] g_val;   // guard word value
		logic [GUARD_BITS-1:0] a_len;   // length word of pair A
	} rle_ctrl_t;

	localparam int CTRL_BITS = $bits(rle_ctrl_t);

endpackage

// File: rtl/run_length_encoder_guarded.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_encoder_guarded
// Streaming run-length encoder splitting a symbol block into raw-value and
// guarded run-length words.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  symbols   in_valid / in_stall   symbol[63:0], block_end
//  results   out_valid / out_stall stream_kind, value[63:0], step_last,
//                                  block_done
//  guard     cfg_valid / cfg_ready cfg_data[31:0]
//
//  One symbol transaction is accepted per cycle while the command queue
//  (QUEUE_DEPTH entries) has room; in_stall is the queue-full flag decoded
//  from the registered fill count. Results leave one per cycle from the output
//  register while out_stall is low, so the words of a symbol (0 to 4) each take
//  a turn at the back end; the sustained rate is set by that single output port.
//  A result reaches the output via the command queue and the output register.
//  Reset leaves no run open and the guard at one; cfg_ready is always high.
// ----------------------------------------------------------------------------
module run_length_encoder_guarded #(
	parameter int SYMBOL_BITS = rle_pkg::SYMBOL_BITS_DEF,
	parameter int QUEUE_DEPTH = rle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rle_pkg::VALUE_BITS-1:0]  symbol,
	input  logic                            block_end,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            stream_kind,
	output logic [rle_pkg::VALUE_BITS-1:0]  value,
	output logic                            step_last,
	output logic                            block_done,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rle_pkg::GUARD_BITS-1:0]  cfg_data
);

	localparam int QW = rle_pkg::CTRL_BITS + 2 * SYMBOL_BITS;

	logic                   accept;
	logic                   push;
	logic                   pop;
	logic                   head_valid;
	logic                   full;
	rle_pkg::rle_ctrl_t     cmd_ctrl;
	logic [SYMBOL_BITS-1:0] cmd_a_sym;
	logic [SYMBOL_BITS-1:0] cmd_b_sym;
	logic [QW-1:0]          head_data;
	rle_pkg::rle_ctrl_t     head_ctrl;
	logic [SYMBOL_BITS-1:0] head_a_sym;
	logic [SYMBOL_BITS-1:0] head_b_sym;

	assign in_stall  = full;
	assign accept    = in_valid && !full;
	assign cfg_ready = 1'b1;

	// front: run tracking and command build
	rle_front #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.symbol    (symbol),
		.block_end (block_end),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.push      (push),
		.cmd_ctrl  (cmd_ctrl),
		.cmd_a_sym (cmd_a_sym),
		.cmd_b_sym (cmd_b_sym)
	);

	// command queue
	rle_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   ({cmd_ctrl, cmd_a_sym, cmd_b_sym}),
		.pop       (pop),
		.rd_data   (head_data),
		.not_empty (head_valid),
		.full      (full)
	);

	assign {head_ctrl, head_a_sym, head_b_sym} = head_data;

	// back: word expansion and output register
	rle_back #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_ctrl   (head_ctrl),
		.head_a_sym  (head_a_sym),
		.head_b_sym  (head_b_sym),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.stream_kind (stream_kind),
		.value       (value),
		.step_last   (step_last),
		.block_done  (block_done)
	);

endmodule

// File: rtl/rle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_front
// Tracks the open run, classifies each symbol and builds one command
// describing the result words it causes. Also holds the guard register.
// ----------------------------------------------------------------------------
module rle_front #(
	parameter int SYMBOL_BITS = rle_pkg::SYMBOL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// symbol transaction
	input  logic                               accept,
	input  logic [rle_pkg::VALUE_BITS-1:0]     symbol,
	input  logic                               block_end,
	// guard register write
	input  logic                               cfg_we,
	input  logic [rle_pkg::GUARD_BITS-1:0]     cfg_data,
	// command towards the queue
	output logic                               push,
	output rle_pkg::rle_ctrl_t                 cmd_ctrl,
	output logic [SYMBOL_BITS-1:0]             cmd_a_sym,
	output logic [SYMBOL_BITS-1:0]             cmd_b_sym
);

	logic [rle_pkg::GUARD_BITS-1:0] guard_q;
	logic [SYMBOL_BITS-1:0]         run_sym_q;
	logic [rle_pkg::GUARD_BITS-1:0] run_cnt_q;
	logic                           run_open_q;

	logic [SYMBOL_BITS-1:0]         sym;
	logic [rle_pkg::GUARD_BITS-1:0] g_eff;
	logic [rle_pkg::GUARD_BITS:0]   cnt_inc;
	logic [rle_pkg::GUARD_BITS-1:0] cnt_same;
	logic                           over;
	logic [SYMBOL_BITS-1:0]         nxt_sym;
	logic [rle_pkg::GUARD_BITS-1:0] nxt_cnt;
	logic                           nxt_open;

	assign sym   = symbol[SYMBOL_BITS-1:0];
	// a guard of zero behaves as one
	assign g_eff = (guard_q == '0) ? rle_pkg::GUARD_BITS'(1) : guard_q;

	// continuing run: count up, split off a guard word on overflow
	assign cnt_inc  = {1'b0, run_cnt_q} + (rle_pkg::GUARD_BITS+1)'(1);
	assign over     = cnt_inc > {1'b0, g_eff};
	assign cnt_same = over ? rle_pkg::GUARD_BITS'(cnt_inc - {1'b0, g_eff})
	                       : cnt_inc[rle_pkg::GUARD_BITS-1:0];

	// classify the symbol and build the command
	always_comb begin
		cmd_ctrl       = '0;
		cmd_ctrl.g_val = g_eff;
		cmd_ctrl.last  = block_end;
		cmd_a_sym      = run_sym_q;
		cmd_b_sym      = sym;
		nxt_sym        = sym;
		nxt_cnt        = rle_pkg::GUARD_BITS'(1);
		nxt_open       = 1'b1;
		if (!run_open_q) begin
			// first symbol of a block opens a run
			cmd_ctrl.a_en  = block_end;
			cmd_a_sym      = sym;
			cmd_ctrl.a_len = '0;
		end else if (sym == run_sym_q) begin
			cmd_ctrl.g_en  = over;
			cmd_ctrl.a_en  = block_end;
			cmd_ctrl.a_len = cnt_same - rle_pkg::GUARD_BITS'(1);
			nxt_sym        = run_sym_q;
			nxt_cnt        = cnt_same;
		end else begin
			// differing symbol closes the old run
			cmd_ctrl.a_en  = 1'b1;
			cmd_ctrl.a_len = (run_cnt_q == '0) ? '0
			                 : run_cnt_q - rle_pkg::GUARD_BITS'(1);
			cmd_ctrl.b_en  = block_end;
		end
		if (block_end) begin
			nxt_sym  = '0;
			nxt_cnt  = '0;
			nxt_open = 1'b0;
		end
	end

	assign push = accept && (cmd_ctrl.g_en || cmd_ctrl.a_en || cmd_ctrl.b_en);

	// run state and guard register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q    <= rle_pkg::GUARD_RESET;
			run_sym_q  <= '0;
			run_cnt_q  <= '0;
			run_open_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				guard_q <= cfg_data;
			end
			if (accept) begin
				run_sym_q  <= nxt_sym;
				run_cnt_q  <= nxt_cnt;
				run_open_q <= nxt_open;
			end
		end
	end

endmodule

// File: rtl/rle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_queue
// Small register FIFO carrying commands from front to back.
// ----------------------------------------------------------------------------
module rle_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty,
	output logic             full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign rd_data   = mem[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == CW'(DEPTH);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/rle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_back
// Expands the command at the queue head into result words, one per cycle
// while out_stall allows, through an output register.
// ----------------------------------------------------------------------------
module rle_back #(
	parameter int SYMBOL_BITS = rle_pkg::SYMBOL_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// queue head
	input  logic                            head_valid,
	input  rle_pkg::rle_ctrl_t              head_ctrl,
	input  logic [SYMBOL_BITS-1:0]          head_a_sym,
	input  logic [SYMBOL_BITS-1:0]          head_b_sym,
	output logic                            pop,
	// result transaction
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            stream_kind,
	output logic [rle_pkg::VALUE_BITS-1:0]  value,
	output logic                            step_last,
	output logic                            block_done
);

	// word slots of a command, in emission order
	localparam logic [2:0] SLOT_G  = 3'd0;
	localparam logic [2:0] SLOT_AR = 3'd1;
	localparam logic [2:0] SLOT_AL = 3'd2;
	localparam logic [2:0] SLOT_BR = 3'd3;
	localparam logic [2:0] SLOT_BL = 3'd4;
	localparam int NSLOT = 5;

	logic [2:0]             slot_q;
	logic                   out_valid_q;
	logic                   kind_q;
	logic [rle_pkg::VALUE_BITS-1:0] value_q;
	logic                   last_q;
	logic                   done_q;

	logic [NSLOT-1:0]       en;
	logic [2:0]             cur;
	logic [2:0]             top;
	logic                   found;
	logic                   is_last;
	logic                   take;
	logic                   emit;
	logic                   w_kind;
	logic [rle_pkg::VALUE_BITS-1:0] w_value;

	assign en = {head_ctrl.b_en, head_ctrl.b_en, head_ctrl.a_en, head_ctrl.a_en,
	             head_ctrl.g_en};

	// next enabled slot at or after the current one, and the final slot
	always_comb begin
		cur   = slot_q;
		top   = SLOT_G;
		found = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			if (!found && (3'(i) >= slot_q) && en[i]) begin
				cur   = 3'(i);
				found = 1'b1;
			end
			if (en[i]) begin
				top = 3'(i);
			end
		end
	end

	assign is_last = cur == top;

	// word selection
	always_comb begin
		case (cur)
			SLOT_G: begin
				w_kind  = 1'b1;
				w_value = rle_pkg::VALUE_BITS'(head_ctrl.g_val);
			end
			SLOT_AR: begin
				w_kind  = 1'b0;
				w_value = rle_pkg::VALUE_BITS'(head_a_sym);
			end
			SLOT_AL: begin
				w_kind  = 1'b1;
				w_value = rle_pkg::VALUE_BITS'(head_ctrl.a_len);
			end
			SLOT_BR: begin
				w_kind  = 1'b0;
				w_value = rle_pkg::VALUE_BITS'(head_b_sym);
			end
			SLOT_BL: begin
				w_kind  = 1'b1;
				w_value = '0;
			end
			default: begin
				w_kind  = 1'b1;
				w_value = '0;
			end
		endcase
	end

	assign take = !out_valid_q || !out_stall;
	assign emit = take && head_valid;
	assign pop  = emit && is_last;

	// slot sequencing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= SLOT_G;
			out_valid_q <= 1'b0;
			kind_q      <= 1'b0;
			value_q     <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
		end else if (emit) begin
			slot_q      <= is_last ? SLOT_G : cur + 3'd1;
			out_valid_q <= 1'b1;
			kind_q      <= w_kind;
			value_q     <= w_value;
			last_q      <= is_last;
			done_q      <= is_last && head_ctrl.last;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign stream_kind = kind_q;
	assign value       = value_q;
	assign step_last   = last_q;
	assign block_done  = done_q;

endmodule
